/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one samples on clk and is
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CRAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRAT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/crat_pkg.sv */
// ----------------------------------------------------------------------------
// crat_pkg
// Types, sizes and codes shared by the command retry and ack tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crat_pkg;

  // Table, event ring and node sizes.
  localparam int PENDING_SLOTS = 10;
  localparam int EVENT_DEPTH   = 8;
  localparam int NODE_BITS     = 16;

  localparam int SLOT_W  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int EVT_W   = $clog2(EVENT_DEPTH);
  localparam int ID_W    = 16;
  localparam int NODE_W  = 16;
  localparam int TRIES_W = 4;
  localparam int TIMER_W = 16;
  localparam int SLOT_OUT_W = 6;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(PENDING_SLOTS - 1);
  localparam logic [EVT_W-1:0]   EVT_LAST  = EVT_W'(EVENT_DEPTH - 1);
  localparam logic [TRIES_W-1:0] TRIES_MAX = '1;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPT_LIMIT = 1'b1;
  localparam logic [TIMER_W-1:0] ACK_TIMEOUT_RESET   = 16'd800;
  localparam logic [TRIES_W-1:0] ATTEMPT_LIMIT_RESET = 4'd3;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_POP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_IDLE         = 3'd0,
    KIND_TRANSMIT     = 3'd1,
    KIND_FAILED       = 3'd2,
    KIND_ENQUEUED     = 3'd3,
    KIND_REJECTED     = 3'd4,
    KIND_POPPED       = 3'd5,
    KIND_EVENTS_EMPTY = 3'd6,
    KIND_ACK_HANDLED  = 3'd7
  } kind_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   command_id;
    logic [NODE_W-1:0] node_number;
    logic              turn_on;
    logic              has_action;
  } in_item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ID_W-1:0]       out_command_id;
    logic [NODE_W-1:0]     out_node_number;
    logic                  out_turn_on;
    logic [TRIES_W-1:0]    attempt_number;
    logic                  matched;
    logic                  event_dropped;
    logic [SLOT_OUT_W-1:0] slot_used;
  } out_item_t;

  // One entry of the ack event ring.
  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [NODE_BITS-1:0] node;
    logic                 ok;
  } ack_event_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    logic probe;
    logic scan;
    logic capture;
    logic apply;
    logic commit;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_t cmd;
    logic early_reject;
    logic inflight_valid;
    logic cond;
    logic last;
    logic out_free;
  } sts_t;

  // Keep a node number to NODE_BITS bits.
  function automatic logic [NODE_BITS-1:0] node_in(logic [NODE_W-1:0] n);
    logic [NODE_BITS+NODE_W-1:0] w;
    w = {{NODE_BITS{1'b0}}, n};
    return w[NODE_BITS-1:0];
  endfunction

  // Widen or trim a stored node to the result field.
  function automatic logic [NODE_W-1:0] node_out(logic [NODE_BITS-1:0] n);
    logic [NODE_BITS+NODE_W-1:0] w;
    w = {{NODE_W{1'b0}}, n};
    return w[NODE_W-1:0];
  endfunction

endpackage

/* rtl/crat_chan_if.sv */
// ----------------------------------------------------------------------------
// crat channel interfaces
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crat_in_if;
  import crat_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crat_out_if;
  import crat_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/crat_ctrl.sv */
// ----------------------------------------------------------------------------
// crat_ctrl
// Request sequencer: dispatch, in-flight probe, slot scan and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  crat_pkg::sts_t sts,
  output crat_pkg::ctl_t ctl
);
  import crat_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_PROBE    = 5'b00100,
    ST_SCAN     = 5'b01000,
    ST_APPLY    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts.cmd)
          CMD_ENQUEUE: state_next = sts.early_reject ? ST_APPLY : ST_SCAN;
          CMD_ACK:     state_next = sts.inflight_valid ? ST_PROBE : ST_SCAN;
          CMD_TICK:    state_next = sts.inflight_valid ? ST_PROBE : ST_SCAN;
          default:     state_next = ST_APPLY;
        endcase
      end
      ST_PROBE: begin
        // A tick only needs the in-flight slot; an ack without a match falls back to a scan.
        if (sts.cmd == CMD_TICK || sts.cond) state_next = ST_APPLY;
        else state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.cond || sts.last) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    item_ready  = (state == ST_IDLE);
    ctl.latch   = (state == ST_IDLE) && item_valid;
    ctl.probe   = (state == ST_PROBE);
    ctl.scan    = (state == ST_SCAN);
    ctl.capture = ((state == ST_PROBE) && (sts.cmd == CMD_TICK || sts.cond)) ||
                  ((state == ST_SCAN) && sts.cond);
    ctl.apply   = (state == ST_APPLY);
    ctl.commit  = (state == ST_APPLY) && sts.out_free;
  end

  `CRAT_ASSERT_NXT(a_accept_leaves_idle, item_valid && item_ready, state == ST_DISPATCH, "no start")
  `CRAT_ASSERT_NXT(a_commit_returns_idle, ctl.commit, state == ST_IDLE, "not idle after commit")

endmodule

/* rtl/crat_dp.sv */
// ----------------------------------------------------------------------------
// crat_dp
// Pending command table, in-flight timer, ack event ring and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crat_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  crat_pkg::in_item_t                  item_data,
  input  logic                                wr_en,
  input  logic [crat_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [crat_pkg::CFG_DATA_W-1:0]     wr_data,
  input  crat_pkg::ctl_t                      ctl,
  output crat_pkg::sts_t                      sts,
  crat_out_if.source                          result
);
  import crat_pkg::*;

  // Configuration registers.
  logic [TIMER_W-1:0] ack_timeout;
  logic [TRIES_W-1:0] attempt_limit;

  // Latched request and scan state.
  in_item_t          it;
  logic [SLOT_W-1:0] idx;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;

  // Pending table.
  logic                 slot_valid      [PENDING_SLOTS];
  logic [ID_W-1:0]      slot_command_id [PENDING_SLOTS];
  logic [NODE_BITS-1:0] slot_node       [PENDING_SLOTS];
  logic                 slot_light      [PENDING_SLOTS];
  logic [TRIES_W-1:0]   slot_tries      [PENDING_SLOTS];

  // In-flight command.
  logic               inflight_valid;
  logic [SLOT_W-1:0]  inflight_slot;
  logic [TIMER_W-1:0] since_send;

  // Ack event ring.
  ack_event_t       event_ring [EVENT_DEPTH];
  logic [EVT_W-1:0] event_read_ptr;
  logic [EVT_W-1:0] event_write_ptr;

  // Result register.
  logic      out_valid;
  out_item_t out_data;

  // Combinational helpers.
  logic [SLOT_W-1:0]    rd_addr;
  logic                 rd_valid;
  logic [ID_W-1:0]      rd_id;
  logic [NODE_BITS-1:0] rd_node;
  logic                 rd_light;
  logic [TRIES_W-1:0]   rd_tries;
  logic [NODE_BITS-1:0] it_node;
  logic                 early_reject;
  logic [TIMER_W-1:0]   ss_inc;
  logic                 timeout;
  logic [TRIES_W-1:0]   tries_inc;
  logic                 do_transmit;
  logic                 do_fail;
  logic [EVT_W-1:0]     wptr_next;
  logic [EVT_W-1:0]     rptr_next;
  logic                 ring_full;
  logic                 ring_empty;
  logic                 out_free;
  out_item_t            res;

  // Single table read port: in-flight slot, scan index or found slot.
  always_comb begin
    if (ctl.probe) rd_addr = inflight_slot;
    else if (ctl.apply) rd_addr = hit_slot;
    else rd_addr = idx;
    rd_valid = slot_valid[rd_addr];
    rd_id    = slot_command_id[rd_addr];
    rd_node  = slot_node[rd_addr];
    rd_light = slot_light[rd_addr];
    rd_tries = slot_tries[rd_addr];
  end

  // Status for the controller.
  always_comb begin
    it_node      = node_in(it.node_number);
    early_reject = (it_node == '0) || !it.has_action;
    case (it.cmd)
      CMD_ENQUEUE: sts.cond = !rd_valid;
      CMD_ACK:     sts.cond = rd_valid && (rd_id == it.command_id) && (rd_node == it_node);
      CMD_TICK:    sts.cond = rd_valid;
      default:     sts.cond = 1'b0;
    endcase
    out_free           = !out_valid || result.ready;
    sts.cmd            = it.cmd;
    sts.early_reject   = early_reject;
    sts.inflight_valid = inflight_valid;
    sts.last           = (idx == SLOT_LAST);
    sts.out_free       = out_free;
  end

  // Timer, retry count and ring pointer arithmetic.
  always_comb begin
    ss_inc      = (since_send != TIMER_MAX) ? since_send + 1'b1 : since_send;
    timeout     = (ss_inc >= ack_timeout);
    tries_inc   = (rd_tries != TRIES_MAX) ? rd_tries + 1'b1 : rd_tries;
    do_fail     = (it.cmd == CMD_TICK) && inflight_valid && hit && timeout &&
                  (rd_tries >= attempt_limit);
    do_transmit = (it.cmd == CMD_TICK) && hit &&
                  (!inflight_valid || (timeout && (rd_tries < attempt_limit)));
    wptr_next   = (event_write_ptr == EVT_LAST) ? '0 : event_write_ptr + 1'b1;
    rptr_next   = (event_read_ptr == EVT_LAST) ? '0 : event_read_ptr + 1'b1;
    ring_full   = (wptr_next == event_read_ptr);
    ring_empty  = (event_read_ptr == event_write_ptr);
  end

  // Result of the request being committed.
  always_comb begin
    res      = '0;
    res.kind = KIND_IDLE;
    case (it.cmd)
      CMD_ENQUEUE: begin
        res.out_command_id  = it.command_id;
        res.out_node_number = node_out(it_node);
        if (!early_reject && hit) begin
          res.kind      = KIND_ENQUEUED;
          res.slot_used = SLOT_OUT_W'(hit_slot);
        end else begin
          res.kind = KIND_REJECTED;
        end
      end
      CMD_ACK: begin
        res.kind            = KIND_ACK_HANDLED;
        res.out_command_id  = it.command_id;
        res.out_node_number = node_out(it_node);
        res.matched         = hit;
        res.event_dropped   = ring_full;
      end
      CMD_TICK: begin
        if (do_transmit || do_fail) begin
          res.out_command_id  = rd_id;
          res.out_node_number = node_out(rd_node);
          res.slot_used       = SLOT_OUT_W'(hit_slot);
          if (do_transmit) begin
            res.kind           = KIND_TRANSMIT;
            res.out_turn_on    = rd_light;
            res.attempt_number = tries_inc;
          end else begin
            res.kind           = KIND_FAILED;
            res.attempt_number = rd_tries;
          end
        end
      end
      default: begin
        if (ring_empty) begin
          res.kind = KIND_EVENTS_EMPTY;
        end else begin
          res.kind            = KIND_POPPED;
          res.out_command_id  = event_ring[event_read_ptr].id;
          res.out_node_number = node_out(event_ring[event_read_ptr].node);
          res.matched         = event_ring[event_read_ptr].ok;
        end
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout   <= ACK_TIMEOUT_RESET;
      attempt_limit <= ATTEMPT_LIMIT_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_ACK_TIMEOUT) ack_timeout <= wr_data[TIMER_W-1:0];
      if (wr_index == REG_ATTEMPT_LIMIT) attempt_limit <= wr_data[TRIES_W-1:0];
    end
  end

  // Request latch and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      it  <= item_data;
      idx <= '0;
      hit <= 1'b0;
    end else begin
      if (ctl.scan && idx != SLOT_LAST) idx <= idx + 1'b1;
      if (ctl.capture) begin
        hit      <= sts.cond;
        hit_slot <= rd_addr;
      end
    end
  end

  // Control state: valid bits, in-flight mark, timer and ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PENDING_SLOTS; i++) slot_valid[i] <= 1'b0;
      inflight_valid  <= 1'b0;
      inflight_slot   <= '0;
      since_send      <= '0;
      event_read_ptr  <= '0;
      event_write_ptr <= '0;
    end else if (ctl.commit) begin
      case (it.cmd)
        CMD_ENQUEUE: begin
          if (!early_reject && hit) slot_valid[hit_slot] <= 1'b1;
        end
        CMD_ACK: begin
          if (hit) begin
            slot_valid[hit_slot] <= 1'b0;
            if (inflight_valid && inflight_slot == hit_slot) begin
              inflight_valid <= 1'b0;
              inflight_slot  <= '0;
            end
          end
          if (!ring_full) event_write_ptr <= wptr_next;
        end
        CMD_TICK: begin
          if (inflight_valid) begin
            if (!hit) begin
              inflight_valid <= 1'b0;
              inflight_slot  <= '0;
            end else if (do_transmit) begin
              since_send <= '0;
            end else begin
              since_send <= ss_inc;
            end
            if (do_fail) begin
              slot_valid[hit_slot] <= 1'b0;
              inflight_valid       <= 1'b0;
              inflight_slot        <= '0;
            end
          end else if (hit) begin
            inflight_valid <= 1'b1;
            inflight_slot  <= hit_slot;
            since_send     <= '0;
          end
        end
        default: begin
          if (!ring_empty) event_read_ptr <= rptr_next;
        end
      endcase
    end
  end

  // Table payload and ring entries.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (it.cmd == CMD_ENQUEUE && !early_reject && hit) begin
        slot_command_id[hit_slot] <= it.command_id;
        slot_node[hit_slot]       <= it_node;
        slot_light[hit_slot]      <= it.turn_on;
        slot_tries[hit_slot]      <= '0;
      end
      if (do_transmit) slot_tries[hit_slot] <= tries_inc;
      if (it.cmd == CMD_ACK && !ring_full) begin
        event_ring[event_write_ptr].id   <= it.command_id;
        event_ring[event_write_ptr].node <= it_node;
        event_ring[event_write_ptr].ok   <= hit;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) out_data <= res;
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  `CRAT_ASSERT_IMP(a_inflight_slot_pending, inflight_valid, slot_valid[inflight_slot], "stale slot")
  `CRAT_ASSERT_NXT(a_commit_shows_result, ctl.commit, result.valid, "no result after commit")

endmodule

/* rtl/command_retry_ack_tracker.sv */
// ----------------------------------------------------------------------------
// command_retry_ack_tracker
// Pending light-command table with stop-and-wait retransmission and an
// ack event ring.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake        Payload
//   item      in    valid / ready    cmd, command_id, node_number, turn_on,
//                                    has_action
//   result    out   valid / ready    kind, out_command_id, out_node_number,
//                                    out_turn_on, attempt_number, matched,
//                                    event_dropped, slot_used
//   wr_*      in    wr_en strobe     wr_index, wr_data (0 ack_timeout,
//                                    1 attempt_limit)
//
// One request is in the block at a time; each request gives one result.
// Pop and rejected enqueue go from dispatch straight to apply; enqueue, ack
// and tick scan the table one slot per cycle (PENDING_SLOTS slots); with a
// command in flight, a tick probes only its slot and an ack probes it first.
// A new request is accepted in the cycle after the previous one commits into
// the result register, which holds it while the result side stalls.
// Reset is synchronous; it empties the table and the ring and restores the
// configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_retry_ack_tracker (
  input  logic                             clk,
  input  logic                             rst,
  crat_in_if.sink                          item,
  crat_out_if.source                       result,
  input  logic                             wr_en,
  input  logic [crat_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [crat_pkg::CFG_DATA_W-1:0]  wr_data
);
  import crat_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic ready;

  // Sequencer.
  crat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  // Table, timer, ring and result register.
  crat_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item_data (item.data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .ctl       (ctl),
    .sts       (sts),
    .result    (result)
  );

  assign item.ready = ready;

endmodule
